/* hw/rtl/sha256_stream_hasher_top_defines.svh */
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top_defines
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Assert that an implication holds on every clock edge outside reset.
`define SHS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert that an implication's consequent holds in the cycle after its antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/shs_pkg.sv */
// ---------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and functions of the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package shs_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueAw = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
      rotr = (x >> r) | (x << (32 - r));
   endfunction

endpackage

/* hw/rtl/sha256_stream_hasher_top.sv */
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream; eight digest words per message.
// ---------------------------------------------------------------------------
//  channel  | handshake     | payload
//  request  | push / full   | data_byte, byte_present, end_of_message
//  response | empty / pop   | digest_word, word_index, last_word
//
//  Each byte word is packed into the block; every 64th byte starts the 64
//  rounds and a fold on the single shared round unit.
//  Closing a message adds padding (one pad byte per cycle), a length step,
//  one or two compressions, and eight result words.
//  Reset is synchronous and loads the initial hash; a 4-deep queue takes
//  words while the back end compresses or the digest waits.
module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import shs_pkg::*;

   item_type in_item, head_item;
   logic     head_valid, take;

   // Bundle the request fields into one queue entry.
   assign in_item = '{data_byte: req_data_byte, byte_present: req_byte_present,
                      end_of_message: req_end_of_message};

   shs_front u_front (
      .clock, .reset, .push, .push_item(in_item), .full,
      .take, .head_item, .head_valid);

   shs_back u_back (
      .clock, .reset, .head_item, .head_valid, .take,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_digest_word, .rsp_word_index,
      .rsp_last_word);
endmodule

/* hw/rtl/shs_front.sv */
// ---------------------------------------------------------------------------
// shs_front
// Input queue: holds words until the back end takes them.
// ---------------------------------------------------------------------------
module shs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  shs_pkg::item_type push_item,
   output logic              full,
   input  logic              take,
   output shs_pkg::item_type head_item,
   output logic              head_valid
);
   import shs_pkg::*;

   item_type           mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full       = (cnt_ff == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ff];
   // Drop words that neither carry a byte nor close a message.
   assign do_push = push && !full && (push_item.byte_present || push_item.end_of_message);
   assign do_pop  = take && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueAw+1)'(do_push) - (QueueAw+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end
endmodule

/* hw/rtl/shs_back.sv */
// ---------------------------------------------------------------------------
// shs_back
// Packs bytes, pads, runs the 64 rounds one per cycle and emits the digest.
// ---------------------------------------------------------------------------
module shs_back (
   input  logic              clock,
   input  logic              reset,
   input  shs_pkg::item_type head_item,
   input  logic              head_valid,
   output logic              take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last_word
);
   import shs_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ROUND = 6'b000010,
      S_FOLD  = 6'b000100,
      S_PAD   = 6'b001000,
      S_LEN   = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type    st_ff, st_in;
   logic [31:0]  blk_ff [16];
   logic [31:0]  chain_ff [8];
   logic [31:0]  var_ff [8];
   logic [5:0]   fill_ff;
   logic [63:0]  total_ff;
   logic [5:0]   rnd_ff;
   logic [2:0]   idx_ff;
   logic         fin_ff;      // message closing; emit after the length block
   logic         pend_ff;     // pad byte still owed
   logic         len_done_ff; // length placed; this compression ends the message

   logic [31:0]  w15, w2, s0, s1, wnew, wcur, t1, t2, e, a;
   logic [7:0]   put_val;
   logic         put_en;
   logic [63:0]  bits;

   function automatic logic rsp_idx_last();
      rsp_idx_last = (idx_ff == 3'd7);
   endfunction

   assign bits = {total_ff[60:0], 3'b000};
   assign take = (st_ff == S_IDLE) && head_valid;
   assign rsp_empty       = (st_ff != S_EMIT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_comb begin
      w15  = blk_ff[1];
      w2   = blk_ff[14];
      s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      wnew = blk_ff[0] + s0 + blk_ff[9] + s1;
      wcur = blk_ff[0];
      e    = var_ff[4];
      a    = var_ff[0];
      t1   = var_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
             ((e & var_ff[5]) ^ (~e & var_ff[6])) + RoundK[rnd_ff] + wcur;
      t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
             ((a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // Next state, and byte placement source in IDLE (message byte) and PAD (pad or zero).
   always_comb begin
      put_en  = 1'b0;
      put_val = 8'h00;
      st_in   = st_ff;
      unique case (st_ff)
         S_IDLE: if (take) begin
            put_en  = head_item.byte_present;
            put_val = head_item.data_byte;
            if (head_item.byte_present && fill_ff == 6'd63) st_in = S_ROUND;
            else if (head_item.end_of_message) st_in = S_PAD;
         end
         S_PAD: begin
            put_en  = 1'b1;
            put_val = pend_ff ? PadByte : 8'h00;
            if (fill_ff == 6'd63) st_in = S_ROUND;
            else if (fill_ff == 6'd55) st_in = S_LEN;
         end
         S_LEN:   st_in = S_ROUND;
         S_ROUND: if (rnd_ff == 6'd63) st_in = S_FOLD;
         // A closing message keeps padding until the length block is done.
         S_FOLD:  st_in = fin_ff ? (len_done_ff ? S_EMIT : S_PAD) : S_IDLE;
         S_EMIT:  if (rsp_pop && rsp_idx_last()) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // Block words: hold packed bytes and the length; rotate as the schedule during rounds.
   always_ff @(posedge clock) begin
      if (put_en) begin
         if (fill_ff[1:0] == 2'd0) blk_ff[fill_ff[5:2]] <= {put_val, 24'h0};
         else blk_ff[fill_ff[5:2]][(5'd3 - 5'(fill_ff[1:0])) * 8 +: 8] <= put_val;
      end else if (st_ff == S_LEN) begin
         blk_ff[14] <= bits[63:32];
         blk_ff[15] <= bits[31:0];
      end else if (st_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) blk_ff[i] <= blk_ff[i+1];
         blk_ff[15] <= wnew;
      end
      if (st_ff == S_ROUND) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end else if (st_in == S_ROUND) begin
         for (int j = 0; j < 8; j++) var_ff[j] <= chain_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         fill_ff     <= '0;
         total_ff    <= '0;
         rnd_ff      <= '0;
         idx_ff      <= '0;
         fin_ff      <= 1'b0;
         pend_ff     <= 1'b0;
         len_done_ff <= 1'b0;
         for (int j = 0; j < 8; j++) chain_ff[j] <= InitHash[j];
      end else begin
         st_ff <= st_in;
         if (put_en) fill_ff <= fill_ff + 6'd1;
         if (st_ff == S_IDLE && take) begin
            if (head_item.byte_present) total_ff <= total_ff + 64'd1;
            if (head_item.end_of_message) begin
               fin_ff  <= 1'b1;
               pend_ff <= 1'b1;
            end
         end
         if (st_ff == S_PAD) pend_ff <= 1'b0;
         if (st_ff == S_LEN) begin
            fill_ff     <= '0;
            len_done_ff <= 1'b1;
         end
         if (st_ff == S_ROUND) rnd_ff <= rnd_ff + 6'd1;
         if (st_ff == S_FOLD) begin
            for (int j = 0; j < 8; j++) chain_ff[j] <= chain_ff[j] + var_ff[j];
            len_done_ff <= 1'b0;
         end
         if (st_ff == S_EMIT && rsp_pop) begin
            idx_ff <= idx_ff + 3'd1;
            if (rsp_idx_last()) begin
               for (int j = 0; j < 8; j++) chain_ff[j] <= InitHash[j];
               total_ff <= '0;
               fin_ff   <= 1'b0;
               fill_ff  <= '0;
            end
         end
      end
   end
endmodule

/* hw/rtl/shs_checker.sv */
// ---------------------------------------------------------------------------
// shs_checker
// Port-level checks on the digest stream.
// ---------------------------------------------------------------------------
`include "sha256_stream_hasher_top_defines.svh"
module shs_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last_word
);
   `SHS_ASSERT_IMPL(a_last, clock, reset, !empty, rsp_last_word == (rsp_word_index == 3'd7), "last flag mismatch")
   `SHS_ASSERT_NEXT(a_step, clock, reset, !empty && pop && !rsp_last_word, !empty && rsp_word_index == $past(rsp_word_index) + 3'd1, "index did not advance")
   `SHS_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_word_index), "word dropped")
endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
   .clock, .reset, .empty, .pop, .rsp_word_index, .rsp_last_word);
